FILE: design/mtf_pkg.sv
// Shared types and constants for the move-to-front coder.
// No dependencies; every design file imports this package.
package mtf_pkg;

    localparam int ALPHABET = 256;
    localparam int IDX_W    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int SYM_W    = 8;
    localparam int GROUP    = 16;
    localparam int NGROUP   = (ALPHABET + GROUP - 1) / GROUP;

    localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(ALPHABET - 1);

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_GATHER,
        ST_RESOLVE,
        ST_UPDATE
    } t_state;

    // Control broadcast from the sequencer to every cell of the list.
    typedef struct packed {
        logic             load_identity;
        logic             match;
        logic             update;
        logic             decode;
        logic [SYM_W-1:0] key;
        logic [IDX_W-1:0] pos;
        logic [SYM_W-1:0] sym;
    } t_cell_ctrl;

endpackage

FILE: design/mtf_cell.sv
// One entry of the recency list: holds a symbol, flags a hit, and shifts.
// Depends on mtf_pkg.
module mtf_cell
    import mtf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctrl       i_ctrl,
    input  logic [SYM_W-1:0] i_prev_entry,
    output logic [SYM_W-1:0] o_entry,
    output logic             o_hit
);

    logic [SYM_W-1:0] r_entry;
    logic             r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= SYM_W'(i_index);
            r_hit   <= 1'b0;
        end else begin
            if (i_ctrl.load_identity) begin
                r_entry <= SYM_W'(i_index);
            end else if (i_ctrl.update && (i_index <= i_ctrl.pos)) begin
                // The front cell takes the moved symbol; the others take
                // the entry of their left neighbor.
                r_entry <= (i_index == '0) ? i_ctrl.sym : i_prev_entry;
            end
            if (i_ctrl.match) begin
                r_hit <= i_ctrl.decode ? (i_index == i_ctrl.key[IDX_W-1:0])
                                       : (r_entry == i_ctrl.key);
            end
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

FILE: design/mtf_reduce.sv
// Two-level registered OR tree that turns the one-hot hit row into the
// hit position and the symbol held there. Depends on mtf_pkg.
module mtf_reduce
    import mtf_pkg::*;
(
    input  logic                             i_clk,
    input  logic [ALPHABET-1:0]              i_hits,
    input  logic [ALPHABET-1:0][SYM_W-1:0]   i_entries,
    output logic [IDX_W-1:0]                 o_pos,
    output logic [SYM_W-1:0]                 o_sym
);

    logic [NGROUP-1:0][IDX_W-1:0] r_grp_pos;
    logic [NGROUP-1:0][SYM_W-1:0] r_grp_sym;
    logic [NGROUP-1:0][IDX_W-1:0] n_grp_pos;
    logic [NGROUP-1:0][SYM_W-1:0] n_grp_sym;
    logic [IDX_W-1:0]             r_pos;
    logic [SYM_W-1:0]             r_sym;
    logic [IDX_W-1:0]             n_pos;
    logic [SYM_W-1:0]             n_sym;

    // Only one cell hits, so an OR of the gated values selects it.
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            n_grp_pos[g] = '0;
            n_grp_sym[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < ALPHABET) begin
                    if (i_hits[g * GROUP + k]) begin
                        n_grp_pos[g] = n_grp_pos[g] | IDX_W'(g * GROUP + k);
                        n_grp_sym[g] = n_grp_sym[g] | i_entries[g * GROUP + k];
                    end
                end
            end
        end
    end

    always_comb begin
        n_pos = '0;
        n_sym = '0;
        for (int g = 0; g < NGROUP; g++) begin
            n_pos = n_pos | r_grp_pos[g];
            n_sym = n_sym | r_grp_sym[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_pos <= n_grp_pos;
        r_grp_sym <= n_grp_sym;
        r_pos     <= n_pos;
        r_sym     <= n_sym;
    end

    assign o_pos = r_pos;
    assign o_sym = r_sym;

endmodule

FILE: design/move_to_front_coder.sv
// Move-to-front coder: sequencer, configuration register and output stage.
// Depends on mtf_pkg, mtf_cell and mtf_reduce.
//
// Usage:
//   s_axis carries one transaction per byte: tdata is the byte to encode or
//   the list position to decode, tuser set restarts the list in identity
//   order before that byte. m_axis returns one transaction per input: the
//   position when encoding, the recovered byte when decoding.
//   The cfg channel writes the direction bit (0 encode, 1 decode); write it
//   only while no transaction is in flight. o_cfg_ready is always high.
// Processing:
//   Each item goes in turn through accept, compare in every cell, two levels
//   of the registered OR tree that locates the hit, and the list shift.
//   The result is registered with the list shift, and the next item is
//   accepted only after that, so items do not overlap. The shift waits
//   while m_axis holds a result that has not been taken.
// Reset and stalls:
//   Reset (synchronous, active low) puts the list in identity order and
//   selects encoding. While m_axis is stalled with a result waiting, one
//   further item is processed up to the shift and then holds there.
module move_to_front_coder
    import mtf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data,      // direction
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,    // [7:0] in_value
    input  logic             s_axis_tuser,    // [0] block_start
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata     // [7:0] out_value
);

    t_state                       r_state;
    t_state                       n_state;
    logic                         r_direction;
    logic [SYM_W-1:0]             r_key;
    logic                         r_out_valid;
    logic [7:0]                   r_out_data;
    logic                         accept;
    logic                         out_free;
    t_cell_ctrl                   ctrl;
    logic [ALPHABET-1:0]          hits;
    logic [ALPHABET-1:0][SYM_W-1:0] entries;
    logic [IDX_W-1:0]             found_pos;
    logic [SYM_W-1:0]             found_sym;
    logic [SYM_W-1:0]             clamped;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign clamped       = ({1'b0, s_axis_tdata} >= 9'(ALPHABET)) ? SYM_LAST
                                                                 : s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_direction <= DIR_ENCODE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_direction <= i_cfg_data;
            end
            if (ctrl.update) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= clamped;
        end
        if (ctrl.update) begin
            r_out_data <= (r_direction == DIR_DECODE) ? 8'(found_sym)
                                                      : 8'(found_pos);
        end
    end

    always_comb begin
        n_state            = r_state;
        ctrl.load_identity = 1'b0;
        ctrl.match         = 1'b0;
        ctrl.update        = 1'b0;
        ctrl.decode        = (r_direction == DIR_DECODE);
        ctrl.key           = r_key;
        ctrl.pos           = ctrl.decode ? r_key[IDX_W-1:0] : found_pos;
        ctrl.sym           = ctrl.decode ? found_sym : r_key;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    ctrl.load_identity = s_axis_tuser;
                    n_state            = ST_MATCH;
                end
            end
            ST_MATCH: begin
                ctrl.match = 1'b1;
                n_state    = ST_GATHER;
            end
            ST_GATHER: begin
                n_state = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    ctrl.update = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < ALPHABET; i++) begin : g_cell
        logic [SYM_W-1:0] prev_entry;
        if (i == 0) begin : g_front
            assign prev_entry = '0;
        end else begin : g_rest
            assign prev_entry = entries[i-1];
        end
        mtf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (IDX_W'(i)),
            .i_ctrl       (ctrl),
            .i_prev_entry (prev_entry),
            .o_entry      (entries[i]),
            .o_hit        (hits[i])
        );
    end

    mtf_reduce u_reduce (
        .i_clk     (i_clk),
        .i_hits    (hits),
        .i_entries (entries),
        .o_pos     (found_pos),
        .o_sym     (found_sym)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The list is a permutation, so exactly one cell hits.
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GATHER) |-> $onehot(hits))
        else $error("hit row is not one-hot");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_MATCH))
        else $error("accepted item did not start the compare");

    a_update_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.update |=> (m_axis_tvalid && (r_state == ST_IDLE)))
        else $error("list update did not present a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !ctrl.update)
        else $error("pending result overwritten");

endmodule
